// ===== rtl/u8cjk_pkg.sv =====
// ----------------------------------------------------------------------------
// u8cjk_pkg: shared types and constants for the UTF-8 CJK detector
// Holds the field widths, the decoder status type and the range classifier.
// ----------------------------------------------------------------------------
package u8cjk_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int REM_W  = 2;
    localparam int LEN_W  = 3;

    localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

    // Sequence lengths written into the length register.
    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // CJK code point ranges, inclusive.
    localparam logic [CP_W-1:0] KANA_LO    = 21'h003040;
    localparam logic [CP_W-1:0] KANA_HI    = 21'h0030FF;
    localparam logic [CP_W-1:0] UNIFIED_LO = 21'h003400;
    localparam logic [CP_W-1:0] UNIFIED_HI = 21'h009FFF;
    localparam logic [CP_W-1:0] HANGUL_LO  = 21'h00AC00;
    localparam logic [CP_W-1:0] HANGUL_HI  = 21'h00D7AF;
    localparam logic [CP_W-1:0] COMPAT_LO  = 21'h00F900;
    localparam logic [CP_W-1:0] COMPAT_HI  = 21'h00FAFF;
    localparam logic [CP_W-1:0] EXT_BF_LO  = 21'h020000;
    localparam logic [CP_W-1:0] EXT_BF_HI  = 21'h02EBEF;
    localparam logic [CP_W-1:0] COMPSUP_LO = 21'h02F800;
    localparam logic [CP_W-1:0] COMPSUP_HI = 21'h02FA1F;
    localparam logic [CP_W-1:0] EXT_GH_LO  = 21'h030000;
    localparam logic [CP_W-1:0] EXT_GH_HI  = 21'h0323AF;

    // What the decoder reports for the byte it consumes in a cycle.
    typedef struct packed {
        logic terminated;  // the byte was the string terminator
        logic has_cjk;     // flag value to deliver when terminated
        logic found;       // current sticky hit flag
    } dec_status_t;

    function automatic logic in_cjk_range(input logic [CP_W-1:0] cp);
        logic hit;
        hit = ((cp >= KANA_LO)    && (cp <= KANA_HI))
           || ((cp >= UNIFIED_LO) && (cp <= UNIFIED_HI))
           || ((cp >= HANGUL_LO)  && (cp <= HANGUL_HI))
           || ((cp >= COMPAT_LO)  && (cp <= COMPAT_HI))
           || ((cp >= EXT_BF_LO)  && (cp <= EXT_BF_HI))
           || ((cp >= COMPSUP_LO) && (cp <= COMPSUP_HI))
           || ((cp >= EXT_GH_LO)  && (cp <= EXT_GH_HI));
        return hit;
    endfunction

endpackage

// ===== rtl/u8cjk_if.sv =====
// ----------------------------------------------------------------------------
// u8cjk channel interfaces
// Valid/ready channels for text bytes in and detection flags out.
// ----------------------------------------------------------------------------
interface u8cjk_byte_if;
    logic                          valid;
    logic                          ready;
    logic [u8cjk_pkg::BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8cjk_flag_if;
    logic valid;
    logic ready;
    logic has_cjk;

    modport source (output valid, output has_cjk, input ready);
    modport sink   (input valid, input has_cjk, output ready);
endinterface

// ===== rtl/utf8_cjk_detector_top.sv =====
// ----------------------------------------------------------------------------
// utf8_cjk_detector_top: UTF-8 string scanner with CJK code point detection
// Decodes a zero-terminated UTF-8 byte stream and reports per string whether
// any complete three- or four-byte code point lies in a CJK range.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Payload            Beats
//  text      in    text_byte [7:0]    one per string byte, 0 ends the string
//  result    out   has_cjk            one per terminator byte
//
// Throughput, set by the decoder state loop, is one byte per cycle unless a
// terminator stalls the input stage; the loop updates sequence state and the
// sticky flag for each byte it consumes. A byte is held in an input register,
// then decoded; a terminator's result is written into the output buffer,
// from which the sink takes it.
// Results go to a two-entry output buffer. Only a terminator can stall the
// input stage, and only when both entries still wait for the sink.
// Reset (rst_n, asynchronous, active low) clears all sequence state, the
// flag and all valid bits.
module utf8_cjk_detector_top
(
    input  logic                clk,
    input  logic                rst_n,
    u8cjk_byte_if.sink          text,
    u8cjk_flag_if.source        result
);

    // Input register stage.
    logic                          stage_valid_reg;
    logic [u8cjk_pkg::BYTE_W-1:0] stage_byte_reg;
    logic                          stage_fire;

    // Output buffer: a head register and a skid entry behind it.
    logic out_valid_reg;
    logic out_flag_reg;
    logic skid_valid_reg;
    logic skid_flag_reg;

    logic                   push;
    logic                   pop;
    u8cjk_pkg::dec_status_t status;

    // Nonzero bytes produce no result and never need buffer room.
    assign stage_fire = stage_valid_reg
                     && ((stage_byte_reg != u8cjk_pkg::TERMINATOR) || !skid_valid_reg);
    assign text.ready = !stage_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            stage_valid_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            stage_byte_reg <= text.text_byte;
        end
    end

    u8cjk_decoder u_decoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (stage_fire),
        .text_byte (stage_byte_reg),
        .status    (status)
    );

    assign push = stage_fire && status.terminated;
    assign pop  = out_valid_reg && result.ready;

    // The skid entry is always the younger one, so it moves to the head
    // whenever the head beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= push;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_flag_reg <= skid_flag_reg;
        end
        else if (push && (!out_valid_reg || pop))
        begin
            out_flag_reg <= status.has_cjk;
        end
        if (push && ((out_valid_reg && !pop) || (pop && skid_valid_reg)))
        begin
            skid_flag_reg <= status.has_cjk;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.has_cjk = out_flag_reg;

    // The skid entry is only ever filled behind a waiting head beat.
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a head beat");

    // A terminator consumed by the decoder always yields a visible result.
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid_reg)
        else $error("terminator consumed but no result pending");

    // The hit flag starts from zero for every new string.
    a_flag_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !status.found)
        else $error("hit flag survived a terminator");

    // A terminator is never consumed while the buffer is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && skid_valid_reg) |-> pop)
        else $error("result pushed into a full buffer");

endmodule

// ===== rtl/u8cjk_decoder.sv =====
// ----------------------------------------------------------------------------
// u8cjk_decoder: UTF-8 sequence state and CJK classification
// Consumes one byte per enabled cycle and keeps the open sequence and hit flag.
// ----------------------------------------------------------------------------
module u8cjk_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [u8cjk_pkg::BYTE_W-1:0] text_byte,
    output u8cjk_pkg::dec_status_t        status
);

    logic [u8cjk_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [u8cjk_pkg::LEN_W-1:0] len_reg, len_next;
    logic [u8cjk_pkg::CP_W-1:0]  acc_reg, acc_next;
    logic                        found_reg, found_next;

    logic                        is_cont;
    logic [u8cjk_pkg::CP_W-1:0]  acc_shift;
    logic [u8cjk_pkg::REM_W-1:0] rem_dec;
    logic                        long_seq;

    assign is_cont   = (text_byte[7:6] == 2'b10);
    assign acc_shift = {acc_reg[u8cjk_pkg::CP_W-7:0], text_byte[5:0]};
    assign rem_dec   = rem_reg - 2'd1;
    assign long_seq  = (len_reg == u8cjk_pkg::LEN_THREE) || (len_reg == u8cjk_pkg::LEN_FOUR);

    always_comb
    begin
        rem_next   = rem_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        if (text_byte == u8cjk_pkg::TERMINATOR)
        begin
            rem_next   = '0;
            len_next   = u8cjk_pkg::LEN_NONE;
            acc_next   = '0;
            found_next = 1'b0;
        end
        else if ((rem_reg != '0) && is_cont)
        begin
            if (rem_dec == '0)
            begin
                // Last continuation byte: classify and close the sequence.
                if (long_seq && u8cjk_pkg::in_cjk_range(acc_shift))
                begin
                    found_next = 1'b1;
                end
                rem_next = '0;
                len_next = u8cjk_pkg::LEN_NONE;
                acc_next = '0;
            end
            else
            begin
                rem_next = rem_dec;
                acc_next = acc_shift;
            end
        end
        else
        begin
            // No sequence open, or a broken one that is dropped here.
            rem_next = '0;
            len_next = u8cjk_pkg::LEN_NONE;
            acc_next = '0;
            if (text_byte[7:5] == 3'b110)
            begin
                acc_next = {{(u8cjk_pkg::CP_W-5){1'b0}}, text_byte[4:0]};
                len_next = u8cjk_pkg::LEN_TWO;
                rem_next = 2'd1;
            end
            else if (text_byte[7:4] == 4'b1110)
            begin
                acc_next = {{(u8cjk_pkg::CP_W-4){1'b0}}, text_byte[3:0]};
                len_next = u8cjk_pkg::LEN_THREE;
                rem_next = 2'd2;
            end
            else if (text_byte[7:3] == 5'b11110)
            begin
                acc_next = {{(u8cjk_pkg::CP_W-3){1'b0}}, text_byte[2:0]};
                len_next = u8cjk_pkg::LEN_FOUR;
                rem_next = 2'd3;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            len_reg   <= u8cjk_pkg::LEN_NONE;
            acc_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (fire)
        begin
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            found_reg <= found_next;
        end
    end

    assign status.terminated = (text_byte == u8cjk_pkg::TERMINATOR);
    assign status.has_cjk    = found_reg;
    assign status.found      = found_reg;

endmodule

// ===== tb/sv/tb_utf8_cjk_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_cjk_detector_top: self-checking testbench for the UTF-8 CJK detector
// Feeds zero-terminated UTF-8 strings through the text channel, predicts each
// has_cjk flag with its own decoder and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_utf8_cjk_detector_top;

    localparam int STALL_PCT       = 12;    // idle chance per cycle on each side
    localparam int HOLD_OFF_CYCLES = 300;   // long back-pressure window on the sink
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_RANGES      = 7;
    localparam int TAIL_CYCLES     = 10;

    logic clk = 1'b0;
    logic rst_n;

    u8cjk_byte_if text_if ();
    u8cjk_flag_if result_if ();

    utf8_cjk_detector_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder shadow state. It follows the accepted byte stream exactly as the
    // block should: open sequence length, continuation bytes still owed, the
    // payload gathered so far and the sticky hit flag of the current string.
    // ------------------------------------------------------------------------
    logic [u8cjk_pkg::REM_W-1:0] seq_left;
    logic [u8cjk_pkg::LEN_W-1:0] seq_len;
    logic [u8cjk_pkg::CP_W-1:0]  cp_gather;
    logic                        cjk_seen;
    logic                        flags_expected[$];

    int error_count  = 0;
    int sent_bytes   = 0;
    int stuck_cycles = 0;
    int hold_count   = 0;

    // Test-side knobs, written with nonblocking assignments by the test sequence.
    logic quiet;        // no idling on either side while set
    logic hold_off_on;  // sink holds ready low for HOLD_OFF_CYCLES once set

    // Boundaries of the seven CJK blocks; even index is the low end, odd the high.
    function automatic logic [u8cjk_pkg::CP_W-1:0] range_edge(input int idx);
        logic [u8cjk_pkg::CP_W-1:0] edge_cp;
        case (idx)
            0:       edge_cp = 21'h003040;
            1:       edge_cp = 21'h0030FF;
            2:       edge_cp = 21'h003400;
            3:       edge_cp = 21'h009FFF;
            4:       edge_cp = 21'h00AC00;
            5:       edge_cp = 21'h00D7AF;
            6:       edge_cp = 21'h00F900;
            7:       edge_cp = 21'h00FAFF;
            8:       edge_cp = 21'h020000;
            9:       edge_cp = 21'h02EBEF;
            10:      edge_cp = 21'h02F800;
            11:      edge_cp = 21'h02FA1F;
            12:      edge_cp = 21'h030000;
            default: edge_cp = 21'h0323AF;
        endcase
        return edge_cp;
    endfunction

    function automatic logic cjk_hit(input logic [u8cjk_pkg::CP_W-1:0] cp);
        logic hit;
        hit = 1'b0;
        for (int r = 0; r < NUM_RANGES; r++)
        begin
            if (cp >= range_edge(2 * r) && cp <= range_edge(2 * r + 1))
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Advance the shadow decoder by one accepted byte. A terminator queues the
    // flag of the finished string and clears everything.
    task automatic decode_byte(input logic [u8cjk_pkg::BYTE_W-1:0] b);
        if (b == u8cjk_pkg::TERMINATOR)
        begin
            flags_expected.push_back(cjk_seen);
            seq_left  = '0;
            seq_len   = u8cjk_pkg::LEN_NONE;
            cp_gather = '0;
            cjk_seen  = 1'b0;
        end
        else if (seq_left != 0 && b[7:6] == 2'b10)
        begin
            cp_gather = {cp_gather[u8cjk_pkg::CP_W-7:0], b[5:0]};
            seq_left  = seq_left - 2'd1;
            if (seq_left == 0)
            begin
                // Only three- and four-byte sequences are classified; overlong
                // and surrogate forms are taken as they stand.
                if (seq_len >= u8cjk_pkg::LEN_THREE && cjk_hit(cp_gather))
                    cjk_seen = 1'b1;
                seq_len   = u8cjk_pkg::LEN_NONE;
                cp_gather = '0;
            end
        end
        else
        begin
            // Any non-continuation byte drops a partial sequence and is then
            // decoded from scratch. Stray continuations and 0xF8..0xFF fall
            // through every branch below and are ignored.
            seq_left  = '0;
            seq_len   = u8cjk_pkg::LEN_NONE;
            cp_gather = '0;
            if (b[7:5] == 3'b110)
            begin
                cp_gather = {16'd0, b[4:0]};
                seq_len   = u8cjk_pkg::LEN_TWO;
                seq_left  = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_gather = {17'd0, b[3:0]};
                seq_len   = u8cjk_pkg::LEN_THREE;
                seq_left  = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_gather = {18'd0, b[2:0]};
                seq_len   = u8cjk_pkg::LEN_FOUR;
                seq_left  = 2'd3;
            end
        end
    endtask

    task automatic note_error(input string what, input logic want, input logic got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] %s: expected has_cjk=%b, got %b", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so each beat is seen exactly as
    // the block saw it. The output beat is checked before the input beat is
    // decoded; a terminator's flag cannot come out in the same cycle anyway.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        logic want;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (flags_expected.size() == 0)
                begin
                    note_error("result beat with no string pending", 1'bx, result_if.has_cjk);
                end
                else
                begin
                    want = flags_expected.pop_front();
                    if (result_if.has_cjk !== want)
                        note_error("has_cjk mismatch", want, result_if.has_cjk);
                end
            end
            if (text_if.valid && text_if.ready)
                decode_byte(text_if.text_byte);
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. It stalls at random, never while quiet is set, and once
    // hold_off_on is raised it keeps ready low for a fixed window counted here,
    // so the output buffer fills and the terminators back up into the input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_on && hold_count < HOLD_OFF_CYCLES)
        begin
            result_if.ready <= 1'b0;
            hold_count      <= hold_count + 1;
        end
        else
        begin
            if (!hold_off_on)
                hold_count <= 0;
            result_if.ready <= quiet || ($urandom_range(99) >= STALL_PCT);
        end
    end

    // Watchdog: a run that moves no beat in either direction for too long is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (text_if.valid && text_if.ready) || (result_if.valid && result_if.ready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Offers one byte, with random idle cycles in front of it unless
    // quiet is set, and returns on the edge that accepts it. Valid stays high
    // on return; the next call either replaces the byte or drops valid.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [u8cjk_pkg::BYTE_W-1:0] b);
        while (!quiet && $urandom_range(99) < STALL_PCT)
        begin
            text_if.valid <= 1'b0;
            @(posedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_byte <= b;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        sent_bytes++;
    endtask

    // Encode cp into a sequence of nbytes (2, 3 or 4) and send the first keep
    // bytes of it. Sending fewer than nbytes leaves a broken sequence.
    task automatic send_char(input logic [u8cjk_pkg::CP_W-1:0] cp, input int nbytes,
                             input int keep);
        logic [u8cjk_pkg::BYTE_W-1:0] enc [4];
        case (nbytes)
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep && i < nbytes; i++)
            send_byte(enc[i]);
    endtask

    // One random character. Half are full three- or four-byte sequences, most of
    // them near the range boundaries; the rest are ASCII, two-byte forms, cut-off
    // sequences and raw noise bytes (stray continuations, invalid leads).
    task automatic send_random_char();
        int                         kind;
        int                         nb;
        logic [u8cjk_pkg::CP_W-1:0] cp;
        kind = $urandom_range(99);
        cp   = u8cjk_pkg::CP_W'($urandom());
        if (kind < 35)
        begin
            cp = range_edge($urandom_range(2 * NUM_RANGES - 1))
               + u8cjk_pkg::CP_W'($urandom_range(2)) - 21'd1;
            // Now and then a BMP value goes out as an overlong four-byte form.
            nb = (cp > 21'h00FFFF || $urandom_range(9) == 0) ? 4 : 3;
            send_char(cp, nb, nb);
        end
        else if (kind < 50)
        begin
            nb = $urandom_range(4, 3);
            send_char(cp, nb, nb);
        end
        else if (kind < 62)
        begin
            send_byte(u8cjk_pkg::BYTE_W'($urandom_range(127, 1)));
        end
        else if (kind < 72)
        begin
            send_char(cp, 2, 2);
        end
        else if (kind < 85)
        begin
            nb = $urandom_range(4, 2);
            send_char(cp, nb, $urandom_range(nb - 1, 1));
        end
        else
        begin
            send_byte(u8cjk_pkg::BYTE_W'($urandom_range(255, 1)));
        end
    endtask

    // Drop valid and wait until every queued flag has come back.
    task automatic wait_results_drained();
        text_if.valid <= 1'b0;
        @(posedge clk);
        while (flags_expected.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked strings for the corner cases of the decoder.
    task automatic test_directed_strings();
        // Empty string.
        send_byte(u8cjk_pkg::TERMINATOR);
        // ASCII extremes, stray continuation bytes and invalid lead bytes: no hit.
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hF8);
        send_byte(8'hFF);
        send_byte(u8cjk_pkg::TERMINATOR);
        // Lowest kana code point, three bytes.
        send_char(21'h003040, 3, 3);
        send_byte(u8cjk_pkg::TERMINATOR);
        // Highest code point of the last supplementary range, four bytes.
        send_char(21'h0323AF, 4, 4);
        send_byte(u8cjk_pkg::TERMINATOR);
        // A two-byte character is never classified, and a terminator that cuts
        // a three-byte sequence short drops it.
        send_char(21'h0000FF, 2, 2);
        send_char(21'h004E00, 3, 2);
        send_byte(u8cjk_pkg::TERMINATOR);
        // A lead broken by an ASCII byte, then a clean ideograph: hit.
        send_byte(8'hE9);
        send_byte(8'h41);
        send_char(21'h004E00, 3, 3);
        send_byte(u8cjk_pkg::TERMINATOR);
    endtask

    // Random strings of mostly zero to four characters, with an occasional
    // long one, until about n_bytes bytes have gone in.
    task automatic test_random_strings(input int n_bytes);
        int start;
        int n_chars;
        start = sent_bytes;
        while (sent_bytes - start < n_bytes)
        begin
            n_chars = ($urandom_range(19) == 0) ? $urandom_range(20, 5) : $urandom_range(4);
            repeat (n_chars)
                send_random_char();
            send_byte(u8cjk_pkg::TERMINATOR);
        end
    endtask

    // Full-rate stretch: neither side idles.
    task automatic test_quiet_stretch();
        quiet <= 1'b1;
        test_random_strings(150);
        quiet <= 1'b0;
    endtask

    // The sink stops for a long window while short strings keep coming, so the
    // output buffer fills and terminators stall the input. The sender then
    // pauses until every flag is out.
    task automatic test_output_hold_off();
        hold_off_on <= 1'b1;
        repeat (16)
        begin
            if ($urandom_range(1) == 1)
                send_random_char();
            send_byte(u8cjk_pkg::TERMINATOR);
        end
        wait_results_drained();
        hold_off_on <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset once, run the tests in turn, let the pipeline
    // settle, and report.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.text_byte = '0;
        result_if.ready   = 1'b0;
        quiet             = 1'b0;
        hold_off_on       = 1'b0;
        seq_left          = '0;
        seq_len           = u8cjk_pkg::LEN_NONE;
        cp_gather         = '0;
        cjk_seen          = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_strings();
        test_random_strings(300);
        // Sender pause: nothing goes in until every flag has come out.
        wait_results_drained();
        test_quiet_stretch();
        test_output_hold_off();
        test_random_strings(380);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && flags_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/u8cjk_pkg.sv
rtl/u8cjk_if.sv
rtl/u8cjk_decoder.sv
rtl/utf8_cjk_detector_top.sv
tb/sv/tb_utf8_cjk_detector_top.sv
